### hdl/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types and constants of the selective-repeat sender core.
// ----------------------------------------------------------------------------
`default_nettype none

package srs_pkg;

	// field widths
	localparam int FRAME_W = 7;
	localparam int WIN_W   = 5;
	localparam int PTR_W   = FRAME_W + 1;
	localparam int FRAME_SPAN = 2 ** FRAME_W;

	// defaults and limits
	localparam int MAX_FRAMES_DEF = 128;
	localparam int MAX_WINDOW     = 16;
	localparam int MAX_RESULTS    = 16;
	localparam int CNT_W          = $clog2(MAX_RESULTS + 1);

	localparam logic [FRAME_W-1:0] TOTAL_RST  = 7'd8;
	localparam logic [WIN_W-1:0]   WINDOW_RST = 5'd4;

	// configuration register indexes
	typedef enum logic {
		CFG_TOTAL_FRAMES = 1'b0,
		CFG_WINDOW_SIZE  = 1'b1
	} cfg_idx_t;

	// event codes
	typedef enum logic [1:0] {
		REQ_START   = 2'd0,
		REQ_TIMEOUT = 2'd1,
		REQ_ACK     = 2'd2,
		REQ_NAK     = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		EMIT_RETX,
		EMIT_NEW,
		EMIT_STATUS
	} emit_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_RETX,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_NEW
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       mark;
		logic       base_inc;
		logic       emit;
		emit_kind_t kind;
		logic       last;
	} srs_cmd_t;

	// datapath to controller
	typedef struct packed {
		req_type_t req;
		logic      fr_ok;
		logic      base_le_tot;
		logic      can_send;
		logic      more;
		logic      acked_rd;
		logic      slot_free;
	} srs_sts_t;

endpackage

`default_nettype wire

### hdl/srs_datapath.sv
// ----------------------------------------------------------------------------
// srs_datapath
// Config registers, window pointers, ack bitmap and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_datapath #(
	parameter int MAX_FRAMES = srs_pkg::MAX_FRAMES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	input  wire logic                         cfg_index,
	input  wire logic [srs_pkg::FRAME_W-1:0]  cfg_data,
	input  wire logic [1:0]                   req_type,
	input  wire logic [srs_pkg::FRAME_W-1:0]  ack_frame,
	input  wire srs_pkg::srs_cmd_t            cmd,
	output srs_pkg::srs_sts_t                 sts,
	input  wire logic                         out_ready,
	output logic                              out_valid,
	output logic                              send_valid,
	output logic [srs_pkg::FRAME_W-1:0]       send_frame,
	output logic                              is_retransmit,
	output logic                              all_done,
	output logic                              last
);

	localparam int MAP_DEPTH = (MAX_FRAMES < srs_pkg::FRAME_SPAN) ?
		MAX_FRAMES : srs_pkg::FRAME_SPAN;
	localparam int IDX_W = $clog2(MAP_DEPTH);
	localparam logic [srs_pkg::FRAME_W-1:0] TOT_CAP = srs_pkg::FRAME_W'(MAP_DEPTH - 1);
	localparam int WIN_CAP_I = (srs_pkg::MAX_WINDOW > (2 ** srs_pkg::WIN_W) - 1) ?
		(2 ** srs_pkg::WIN_W) - 1 : srs_pkg::MAX_WINDOW;
	localparam logic [srs_pkg::WIN_W-1:0] WIN_CAP = srs_pkg::WIN_W'(WIN_CAP_I);

	logic [srs_pkg::FRAME_W-1:0] total_q;
	logic [srs_pkg::WIN_W-1:0]   window_q;
	logic [srs_pkg::PTR_W-1:0]   base_q;
	logic [srs_pkg::PTR_W-1:0]   nnf_q;
	logic [MAP_DEPTH-1:0]        acked_q;
	logic                        acked_rd_q;
	srs_pkg::req_type_t          req_q;
	logic [srs_pkg::FRAME_W-1:0] fr_q;
	logic [srs_pkg::CNT_W-1:0]   k_q;
	logic                        out_valid_q;
	logic                        send_valid_q;
	logic [srs_pkg::FRAME_W-1:0] send_frame_q;
	logic                        retx_q;
	logic                        done_q;
	logic                        last_q;

	logic [srs_pkg::FRAME_W-1:0] tot_eff;
	logic [srs_pkg::PTR_W-1:0]   tot_ext;
	logic [srs_pkg::WIN_W-1:0]   win_eff;
	logic [srs_pkg::PTR_W:0]     limit;
	logic [srs_pkg::PTR_W-1:0]   nnf_p1;
	logic [srs_pkg::CNT_W-1:0]   k_p1;
	logic                        slot_free;
	logic [srs_pkg::FRAME_W-1:0] emit_frame;

	// clamped configuration
	always_comb begin
		tot_eff = (total_q > TOT_CAP) ? TOT_CAP : total_q;
		tot_ext = {1'b0, tot_eff};
		if (window_q == '0) begin
			win_eff = srs_pkg::WIN_W'(1);
		end else if (window_q > WIN_CAP) begin
			win_eff = WIN_CAP;
		end else begin
			win_eff = window_q;
		end
	end

	assign limit     = {1'b0, base_q} + {{(srs_pkg::PTR_W + 1 - srs_pkg::WIN_W){1'b0}}, win_eff};
	assign nnf_p1    = nnf_q + srs_pkg::PTR_W'(1);
	assign k_p1      = k_q + srs_pkg::CNT_W'(1);
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		sts.req         = req_q;
		sts.fr_ok       = (fr_q != '0) && (fr_q <= tot_eff);
		sts.base_le_tot = base_q <= tot_ext;
		sts.can_send    = (k_q < srs_pkg::CNT_W'(srs_pkg::MAX_RESULTS)) &&
			({1'b0, nnf_q} < limit) && (nnf_q <= tot_ext);
		sts.more        = (k_p1 < srs_pkg::CNT_W'(srs_pkg::MAX_RESULTS)) &&
			({1'b0, nnf_p1} < limit) && (nnf_p1 <= tot_ext);
		sts.acked_rd    = acked_rd_q;
		sts.slot_free   = slot_free;
	end

	always_comb begin
		unique case (cmd.kind)
			srs_pkg::EMIT_RETX: begin
				emit_frame = (req_q == srs_pkg::REQ_TIMEOUT) ?
					base_q[srs_pkg::FRAME_W-1:0] : fr_q;
			end
			srs_pkg::EMIT_NEW: begin
				emit_frame = nnf_q[srs_pkg::FRAME_W-1:0];
			end
			default: begin
				emit_frame = '0;
			end
		endcase
	end

	// config and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= srs_pkg::TOTAL_RST;
			window_q <= srs_pkg::WINDOW_RST;
			base_q   <= srs_pkg::PTR_W'(1);
			nnf_q    <= srs_pkg::PTR_W'(1);
			acked_q  <= '0;
			k_q      <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (srs_pkg::cfg_idx_t'(cfg_index))
					srs_pkg::CFG_TOTAL_FRAMES: total_q  <= cfg_data;
					srs_pkg::CFG_WINDOW_SIZE:  window_q <= cfg_data[srs_pkg::WIN_W-1:0];
					default: ;
				endcase
			end
			if (cmd.mark) begin
				acked_q[fr_q[IDX_W-1:0]] <= 1'b1;
			end
			if (cmd.base_inc) begin
				base_q <= base_q + srs_pkg::PTR_W'(1);
			end
			if (cmd.emit && cmd.kind == srs_pkg::EMIT_NEW) begin
				nnf_q <= nnf_p1;
			end
			if (cmd.load) begin
				k_q <= '0;
			end else if (cmd.emit) begin
				k_q <= k_p1;
			end
		end
	end

	// registered bitmap read at the window base
	always_ff @(posedge clk) begin
		acked_rd_q <= acked_q[base_q[IDX_W-1:0]];
		if (cmd.load) begin
			req_q <= srs_pkg::req_type_t'(req_type);
			fr_q  <= ack_frame;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			send_valid_q <= cmd.kind != srs_pkg::EMIT_STATUS;
			send_frame_q <= emit_frame;
			retx_q       <= cmd.kind == srs_pkg::EMIT_RETX;
			done_q       <= base_q > tot_ext;
			last_q       <= cmd.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign send_valid    = send_valid_q;
	assign send_frame    = send_frame_q;
	assign is_retransmit = retx_q;
	assign all_done      = done_q;
	assign last          = last_q;

endmodule

`default_nettype wire

### hdl/srs_ctrl.sv
// ----------------------------------------------------------------------------
// srs_ctrl
// Event sequencer: dispatch, bitmap walk and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire srs_pkg::srs_sts_t sts,
	output srs_pkg::srs_cmd_t      cmd
);

	srs_pkg::state_t state_q;
	srs_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srs_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			srs_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = srs_pkg::ST_DISPATCH;
			end
			srs_pkg::ST_DISPATCH: begin
				unique case (sts.req)
					srs_pkg::REQ_TIMEOUT:
						state_nxt = sts.base_le_tot ? srs_pkg::ST_RETX : srs_pkg::ST_NEW;
					srs_pkg::REQ_ACK:
						state_nxt = sts.fr_ok ? srs_pkg::ST_WALK_RD : srs_pkg::ST_NEW;
					srs_pkg::REQ_NAK:
						state_nxt = sts.fr_ok ? srs_pkg::ST_RETX : srs_pkg::ST_NEW;
					default:
						state_nxt = srs_pkg::ST_NEW;
				endcase
			end
			srs_pkg::ST_RETX: begin
				if (sts.slot_free) begin
					state_nxt = sts.can_send ? srs_pkg::ST_NEW : srs_pkg::ST_IDLE;
				end
			end
			srs_pkg::ST_WALK_RD: begin
				state_nxt = srs_pkg::ST_WALK_CHK;
			end
			srs_pkg::ST_WALK_CHK: begin
				state_nxt = (sts.base_le_tot && sts.acked_rd) ?
					srs_pkg::ST_WALK_RD : srs_pkg::ST_NEW;
			end
			srs_pkg::ST_NEW: begin
				if (sts.slot_free) begin
					state_nxt = (sts.can_send && sts.more) ? srs_pkg::ST_NEW : srs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = srs_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready     = 1'b0;
		cmd.load     = 1'b0;
		cmd.mark     = 1'b0;
		cmd.base_inc = 1'b0;
		cmd.emit     = 1'b0;
		cmd.kind     = srs_pkg::EMIT_STATUS;
		cmd.last     = 1'b0;
		unique case (state_q)
			srs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			srs_pkg::ST_DISPATCH: begin
				cmd.mark = (sts.req == srs_pkg::REQ_ACK) && sts.fr_ok;
			end
			srs_pkg::ST_RETX: begin
				cmd.emit = sts.slot_free;
				cmd.kind = srs_pkg::EMIT_RETX;
				cmd.last = !sts.can_send;
			end
			srs_pkg::ST_WALK_CHK: begin
				cmd.base_inc = sts.base_le_tot && sts.acked_rd;
			end
			srs_pkg::ST_NEW: begin
				cmd.emit = sts.slot_free;
				cmd.kind = sts.can_send ? srs_pkg::EMIT_NEW : srs_pkg::EMIT_STATUS;
				cmd.last = sts.can_send ? !sts.more : 1'b1;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

### hdl/selective_repeat_sender_core.sv
// flow: an event is taken in idle, decoded in the next cycle, and its first result is
// registered from the retx or new state once the result register is free (valid ack:
// each bitmap check takes a read and a check state, and there is one check more than
// the frames the base advances); throughput: one event at a time, results go out one
// per cycle while the result register is free, after the bitmap walk for a valid ack
// reset: base and next frame go to one, the ack bitmap clears at once, config to defaults
// ----------------------------------------------------------------------------
// selective_repeat_sender_core
// Sender side of a selective-repeat ARQ: turns start, timeout, ack and nak
// events into a stream of frame sends and retransmissions.
// ----------------------------------------------------------------------------
`default_nettype none

module selective_repeat_sender_core #(
	parameter int MAX_FRAMES = srs_pkg::MAX_FRAMES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// config write channel
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic                        cfg_index,
	input  wire logic [srs_pkg::FRAME_W-1:0] cfg_data,
	// event channel
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  req_type,
	input  wire logic [srs_pkg::FRAME_W-1:0] ack_frame,
	// result channel
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             send_valid,
	output logic [srs_pkg::FRAME_W-1:0]      send_frame,
	output logic                             is_retransmit,
	output logic                             all_done,
	output logic                             last
);

	srs_pkg::srs_cmd_t cmd;
	srs_pkg::srs_sts_t sts;

	// config beats are taken at any time; the user must send them only while idle, the block itself does not enforce this
	assign cfg_ready = 1'b1;

	// sequencer: one event at a time, emits one result beat per cycle
	// whenever the result register is free
	srs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: window base, next new frame, ack bitmap with registered
	// read at the base, and the result register that lets the next event
	// in while the last beat waits
	srs_datapath #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.req_type      (req_type),
		.ack_frame     (ack_frame),
		.cmd           (cmd),
		.sts           (sts),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.send_valid    (send_valid),
		.send_frame    (send_frame),
		.is_retransmit (is_retransmit),
		.all_done      (all_done),
		.last          (last)
	);

endmodule

`default_nettype wire

### tb/tb_selective_repeat_sender_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_selective_repeat_sender_core
// Self-checking bench for the selective-repeat sender: drives start, timeout,
// ack and nak events under several window and frame-total settings, predicts
// every send beat in a scoreboard and compares the result stream field by field.
// ----------------------------------------------------------------------------

module tb_selective_repeat_sender_core;

	localparam int LIMIT_NS   = 3_000_000;
	localparam int HOLD_CYC   = 400;    // long output stall, fills the core
	localparam int HOLD_AT    = 150;    // event count that kicks off the stall
	localparam int PHASE_EVTS = 52;

	// one result beat as seen on the output channel
	typedef struct packed {
		logic                        sv;
		logic [srs_pkg::FRAME_W-1:0] frame;
		logic                        retx;
		logic                        done;
		logic                        last;
	} srs_beat_t;

	// tracks window state and holds the sends still owed by the core
	class srs_scoreboard;
		int unsigned total_cfg;
		int unsigned window_cfg;
		int unsigned base;
		int unsigned next_new;
		bit          acked[srs_pkg::FRAME_SPAN];
		srs_beat_t   owed_sends[$];
		int          errors;
		int          events;
		int          beats;
		int          retx_beats;
		int          cfg_writes;

		function new();
			total_cfg  = srs_pkg::TOTAL_RST;
			window_cfg = srs_pkg::WINDOW_RST;
			base       = 1;
			next_new   = 1;
		endfunction

		function void write_reg(srs_pkg::cfg_idx_t idx, logic [srs_pkg::FRAME_W-1:0] data);
			cfg_writes++;
			if (idx == srs_pkg::CFG_TOTAL_FRAMES)
				total_cfg = data;
			else
				window_cfg = data[srs_pkg::WIN_W-1:0];
		endfunction

		function srs_beat_t make_beat(logic sv, int unsigned frame, logic retx);
			srs_beat_t b;
			b       = '0;
			b.sv    = sv;
			b.frame = srs_pkg::FRAME_W'(frame);
			b.retx  = retx;
			return b;
		endfunction

		// work out the sends caused by one accepted event
		function void take_event(srs_pkg::req_type_t req, logic [srs_pkg::FRAME_W-1:0] fr);
			int unsigned tot;
			int unsigned win;
			bit          fr_ok;
			srs_beat_t   batch[$];
			events++;
			// a 7-bit total never reaches the bitmap size, so no clamp
			tot = total_cfg;
			win = window_cfg;
			if (win < 1)
				win = 1;
			if (win > srs_pkg::MAX_WINDOW)
				win = srs_pkg::MAX_WINDOW;
			fr_ok = (fr >= 1) && (fr <= tot);
			case (req)
				srs_pkg::REQ_TIMEOUT: begin
					if (base <= tot)
						batch.push_back(make_beat(1'b1, base, 1'b1));
				end
				srs_pkg::REQ_ACK: begin
					if (fr_ok) begin
						acked[fr] = 1'b1;
						while (base <= tot && acked[base])
							base++;
					end
				end
				srs_pkg::REQ_NAK: begin
					if (fr_ok)
						batch.push_back(make_beat(1'b1, fr, 1'b1));
				end
				default: ;
			endcase
			while (batch.size() < srs_pkg::MAX_RESULTS && next_new < base + win &&
				next_new <= tot) begin
				batch.push_back(make_beat(1'b1, next_new, 1'b0));
				next_new++;
			end
			if (batch.size() == 0)
				batch.push_back(make_beat(1'b0, 0, 1'b0));
			foreach (batch[i])
				batch[i].done = (base > tot);
			batch[batch.size()-1].last = 1'b1;
			foreach (batch[i])
				owed_sends.push_back(batch[i]);
		endfunction

		function void check_send(srs_beat_t got);
			srs_beat_t want;
			bit        bad;
			beats++;
			if (got.retx)
				retx_beats++;
			if (owed_sends.size() == 0) begin
				$error("unexpected result beat: frame %0d valid %0b", got.frame, got.sv);
				errors++;
				return;
			end
			want = owed_sends.pop_front();
			bad  = 1'b0;
			if (got.sv !== want.sv) begin
				$error("send_valid: expected %0b, got %0b", want.sv, got.sv);
				bad = 1'b1;
			end
			if (got.frame !== want.frame) begin
				$error("send_frame: expected %0d, got %0d", want.frame, got.frame);
				bad = 1'b1;
			end
			if (got.retx !== want.retx) begin
				$error("is_retransmit: expected %0b, got %0b", want.retx, got.retx);
				bad = 1'b1;
			end
			if (got.done !== want.done) begin
				$error("all_done: expected %0b, got %0b", want.done, got.done);
				bad = 1'b1;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, got.last);
				bad = 1'b1;
			end
			if (bad)
				errors++;
		endfunction

		function int pending();
			return owed_sends.size();
		endfunction
	endclass

	// dut signals, all known from time zero
	logic                        clk           = 1'b0;
	logic                        arst_n        = 1'b0;
	logic                        cfg_valid     = 1'b0;
	logic                        cfg_ready;
	logic                        cfg_index     = srs_pkg::CFG_TOTAL_FRAMES;
	logic [srs_pkg::FRAME_W-1:0] cfg_data      = '0;
	logic                        in_valid      = 1'b0;
	logic                        in_ready;
	logic [1:0]                  req_type      = srs_pkg::REQ_START;
	logic [srs_pkg::FRAME_W-1:0] ack_frame     = '0;
	logic                        out_valid;
	logic                        out_ready     = 1'b0;
	logic                        send_valid;
	logic [srs_pkg::FRAME_W-1:0] send_frame;
	logic                        is_retransmit;
	logic                        all_done;
	logic                        last;

	// idling knobs, set per phase by the stimulus
	int sender_idle_pct = 0;
	int recv_stall_pct  = 0;

	// long stall request: raised once by the stimulus, counted by the receiver
	bit hold_kick = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	int directed_evts = 0;

	srs_scoreboard sb;

	selective_repeat_sender_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.ack_frame     (ack_frame),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.send_valid    (send_valid),
		.send_frame    (send_frame),
		.is_retransmit (is_retransmit),
		.all_done      (all_done),
		.last          (last)
	);

	always #6 clk = ~clk;

	// receiver: random back-pressure, plus one long hold-off counted here
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_kick && !hold_done) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYC - 1;
			hold_done <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: every accepted result beat goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_send({send_valid, send_frame, is_retransmit, all_done, last});
	end

	// offer one event; called and returns at a falling edge, valid left high
	task automatic push_event(srs_pkg::req_type_t req, logic [srs_pkg::FRAME_W-1:0] fr);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		req_type  <= req;
		ack_frame <= fr;
		do
			@(posedge clk);
		while (!in_ready);
		sb.take_event(req, fr);
		// the stall starts while events keep coming, so the input backs up
		if (sb.events == HOLD_AT)
			hold_kick = 1'b1;
		@(negedge clk);
	endtask

	// let the core run dry before touching its registers
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	// write both registers, two beats back to back
	task automatic write_config(logic [srs_pkg::FRAME_W-1:0] total,
		logic [srs_pkg::FRAME_W-1:0] win_data);
		cfg_valid <= 1'b1;
		cfg_index <= srs_pkg::CFG_TOTAL_FRAMES;
		cfg_data  <= total;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_reg(srs_pkg::CFG_TOTAL_FRAMES, total);
		@(negedge clk);
		cfg_index <= srs_pkg::CFG_WINDOW_SIZE;
		cfg_data  <= win_data;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_reg(srs_pkg::CFG_WINDOW_SIZE, win_data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// random frame between base and the next new frame, -1 if none
	function automatic int pick_open_frame(bit only_unacked);
		int cands[$];
		for (int f = sb.base; f < sb.next_new && f < srs_pkg::FRAME_SPAN; f++)
			if (!only_unacked || !sb.acked[f])
				cands.push_back(f);
		if (cands.size() == 0)
			return -1;
		return cands[$urandom_range(cands.size() - 1)];
	endfunction

	// mostly acks of frames in flight, then naks, timeouts and noise
	task automatic random_event();
		int r;
		int f;
		r = $urandom_range(99);
		if (r < 55) begin
			f = pick_open_frame(1'b1);
			if (f >= 0)
				push_event(srs_pkg::REQ_ACK, srs_pkg::FRAME_W'(f));
			else
				push_event(srs_pkg::REQ_START, srs_pkg::FRAME_W'($urandom_range(127)));
		end else if (r < 65) begin
			f = pick_open_frame(1'b0);
			if (f >= 0)
				push_event(srs_pkg::REQ_NAK, srs_pkg::FRAME_W'(f));
			else
				push_event(srs_pkg::REQ_NAK, srs_pkg::FRAME_W'($urandom_range(127)));
		end else if (r < 75) begin
			push_event(srs_pkg::REQ_TIMEOUT, srs_pkg::FRAME_W'($urandom_range(127)));
		end else if (r < 82) begin
			push_event(srs_pkg::REQ_START, srs_pkg::FRAME_W'($urandom_range(127)));
		end else if (r < 91) begin
			// zero, out of range, early or repeated acks
			push_event(srs_pkg::REQ_ACK, srs_pkg::FRAME_W'($urandom_range(127)));
		end else begin
			push_event(srs_pkg::REQ_NAK, srs_pkg::FRAME_W'($urandom_range(127)));
		end
	endtask

	// random phases: totals climb so new frames keep appearing, windows vary
	logic [srs_pkg::FRAME_W-1:0] ph_total[8] =
		'{7'd30, 7'd44, 7'd58, 7'd72, 7'd86, 7'd100, 7'd114, 7'd127};
	// window 0 acts as 1, 31 as the max, 35 loses its upper bits
	logic [srs_pkg::FRAME_W-1:0] ph_win[8]   =
		'{7'd0, 7'd16, 7'd31, 7'd35, 7'd7, 7'd1, 7'd12, 7'd16};
	int                          snd_pct[4]  = '{0, 52, 0, 16};
	int                          rcv_pct[4]  = '{0, 0, 52, 16};

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single frame, window of one
		write_config(7'd1, 7'd1);
		push_event(srs_pkg::REQ_START, 7'd0);      // sends frame 1
		push_event(srs_pkg::REQ_START, 7'd0);      // window full, status only
		push_event(srs_pkg::REQ_TIMEOUT, 7'd0);    // base frame again
		push_event(srs_pkg::REQ_NAK, 7'd1);
		push_event(srs_pkg::REQ_NAK, 7'd2);        // beyond the total, ignored
		push_event(srs_pkg::REQ_ACK, 7'd0);        // frame zero ignored
		push_event(srs_pkg::REQ_ACK, 7'd1);        // base passes the total
		push_event(srs_pkg::REQ_TIMEOUT, 7'd0);    // nothing left to resend
		drain();

		// nothing in flight, then a wide window: nak plus fifteen new hits the cap
		write_config(7'd40, 7'd16);
		push_event(srs_pkg::REQ_NAK, 7'd1);
		push_event(srs_pkg::REQ_START, 7'd0);      // the frame left over by the cap
		push_event(srs_pkg::REQ_TIMEOUT, 7'd0);
		push_event(srs_pkg::REQ_ACK, 7'd40);       // early ack of an unsent frame
		push_event(srs_pkg::REQ_ACK, 7'd41);       // out of range
		push_event(srs_pkg::REQ_ACK, 7'd3);        // out of order, base holds
		push_event(srs_pkg::REQ_ACK, 7'd3);        // repeated
		push_event(srs_pkg::REQ_ACK, 7'd2);        // base walks past 2 and 3
		push_event(srs_pkg::REQ_NAK, 7'd127);
		push_event(srs_pkg::REQ_NAK, 7'd0);
		directed_evts = sb.events;
		drain();

		for (int p = 0; p < 8; p++) begin
			sender_idle_pct = snd_pct[p % 4];
			recv_stall_pct  = rcv_pct[p % 4];
			write_config(ph_total[p], ph_win[p]);
			repeat (PHASE_EVTS) random_event();
			drain();
		end

		// closing wait for any stray beat
		recv_stall_pct = 0;
		repeat (40) @(posedge clk);

		$display("summary: %0d events (%0d directed), %0d result beats, %0d retransmits",
			sb.events, directed_evts, sb.beats, sb.retx_beats);
		$display("summary: %0d register writes, totals 1 to 127, windows 0 to 31, %0d-cycle stall",
			sb.cfg_writes, HOLD_CYC);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#(LIMIT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
